// ----- rtl/brms_pkg.sv -----
// ----------------------------------------------------------------------------
// Block RMS meter package
// Widths and state codes shared by the interfaces and the meter core.
// ----------------------------------------------------------------------------
package brms_pkg;

  localparam int MAX_SAMPLES = 32;
  localparam int SAMPLE_BITS = 16;

  localparam int RMS_W  = 16;
  localparam int USED_W = 6;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int SUM_W  = 2 * SAMPLE_BITS - 2 + CNT_W;
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int WORK_W = 2 * ROOT_W;
  localparam int ALU_W  = (ROOT_W + 3 > CNT_W + 1) ? ROOT_W + 3 : CNT_W + 1;
  localparam int STEP_W = $clog2(WORK_W + 1);
  localparam int RMS_EXT_W = (ROOT_W > RMS_W) ? ROOT_W : RMS_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ACC  = 5'b00010,
    S_DIV  = 5'b00100,
    S_ROOT = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

endpackage

// ----- rtl/brms_if.sv -----
// ----------------------------------------------------------------------------
// Block RMS meter channels
// Valid/ready channels for samples in and results out.
// ----------------------------------------------------------------------------
interface brms_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [brms_pkg::SAMPLE_BITS-1:0] sample;
  logic                                 last_in_block;

  modport source (output valid, output sample, output last_in_block, input ready);
  modport sink   (input valid, input sample, input last_in_block, output ready);
endinterface

interface brms_out_if;
  logic                         valid;
  logic                         ready;
  logic [brms_pkg::RMS_W-1:0]   rms_value;
  logic [brms_pkg::USED_W-1:0]  samples_used;

  modport source (output valid, output rms_value, output samples_used, input ready);
  modport sink   (input valid, input rms_value, input samples_used, output ready);
endinterface

// ----- rtl/block_rms_meter_core.sv -----
// ----------------------------------------------------------------------------
// Block RMS meter core
// Accumulates squared samples per block and, at the end of each block,
// reports floor(sqrt(floor(sum / count))) using one shared subtractor.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload                        Handshake
//  din      in         sample, last_in_block          valid/ready
//  dout     out        rms_value, samples_used        valid/ready
//
// An ordinary sample is squared when it is accepted and then accumulated.
// A final sample also runs a restoring divide (WORK_W = 36 steps) and a
// digit-by-digit root (ROOT_W = 18 steps) on the same subtractor, and then
// loads the output register.
// din is ready only while the sequencer is idle; a stalled output holds the
// sequencer in its last state until the result register frees.
// Reset (synchronous) clears the accumulator, the count and the output valid.

module block_rms_meter_core (
  input  logic           clk,
  input  logic           rst,
  brms_in_if.sink        din,
  brms_out_if.source     dout
);

  brms_pkg::state_t state;

  logic [brms_pkg::SQ_W-1:0]   sq;
  logic                        last_q;
  logic [brms_pkg::SUM_W-1:0]  sum;
  logic [brms_pkg::SUM_W-1:0]  sum_next;
  logic [brms_pkg::CNT_W-1:0]  count;
  logic [brms_pkg::CNT_W-1:0]  count_next;
  logic [brms_pkg::WORK_W-1:0] work;
  logic [brms_pkg::ALU_W-1:0]  rem;
  logic [brms_pkg::ROOT_W-1:0] root;
  logic [brms_pkg::STEP_W-1:0] step;

  logic [brms_pkg::SAMPLE_BITS-1:0] mag;
  logic                             room;

  // Shared subtract-and-compare unit.
  logic [brms_pkg::ALU_W-1:0] alu_a;
  logic [brms_pkg::ALU_W-1:0] alu_b;
  logic [brms_pkg::ALU_W:0]   alu_diff;
  logic                       alu_ge;

  logic [brms_pkg::RMS_EXT_W-1:0] root_ext;
  logic [brms_pkg::RMS_W-1:0]     rms_sat;
  logic                           out_free;

  // The negation of the most negative code wraps to itself, which read
  // unsigned is exactly its magnitude.
  assign mag  = din.sample[brms_pkg::SAMPLE_BITS-1] ? (~din.sample + 1'b1) : din.sample;
  assign room = count < brms_pkg::CNT_W'(brms_pkg::MAX_SAMPLES);

  always_comb begin
    sum_next   = sum;
    count_next = count;
    if (room) begin
      sum_next   = sum + brms_pkg::SUM_W'(sq);
      count_next = count + 1'b1;
    end
  end

  always_comb begin
    if (state == brms_pkg::S_ROOT) begin
      alu_a = {rem[brms_pkg::ALU_W-3:0], work[brms_pkg::WORK_W-1 -: 2]};
      alu_b = brms_pkg::ALU_W'({root, 2'b01});
    end else begin
      alu_a = {rem[brms_pkg::ALU_W-2:0], work[brms_pkg::WORK_W-1]};
      alu_b = brms_pkg::ALU_W'(count);
    end
    alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    alu_ge   = !alu_diff[brms_pkg::ALU_W];
  end

  assign root_ext = brms_pkg::RMS_EXT_W'(root);
  assign rms_sat  = (root_ext > brms_pkg::RMS_EXT_W'({brms_pkg::RMS_W{1'b1}}))
                    ? {brms_pkg::RMS_W{1'b1}} : brms_pkg::RMS_W'(root);
  assign out_free = !dout.valid || dout.ready;

  assign din.ready = (state == brms_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= brms_pkg::S_IDLE;
      sum        <= '0;
      count      <= '0;
      dout.valid <= 1'b0;
    end else begin
      // In the output state the valid flag is decided by the load below.
      if (dout.valid && dout.ready && (state != brms_pkg::S_OUT)) begin
        dout.valid <= 1'b0;
      end
      case (state)
        brms_pkg::S_IDLE: begin
          if (din.valid) begin
            sq     <= mag * mag;
            last_q <= din.last_in_block;
            state  <= brms_pkg::S_ACC;
          end
        end
        brms_pkg::S_ACC: begin
          count <= count_next;
          if (last_q) begin
            sum   <= '0;
            work  <= brms_pkg::WORK_W'(sum_next);
            rem   <= '0;
            step  <= '0;
            state <= brms_pkg::S_DIV;
          end else begin
            sum   <= sum_next;
            state <= brms_pkg::S_IDLE;
          end
        end
        brms_pkg::S_DIV: begin
          work <= {work[brms_pkg::WORK_W-2:0], alu_ge};
          if (step == brms_pkg::STEP_W'(brms_pkg::WORK_W - 1)) begin
            rem   <= '0;
            root  <= '0;
            step  <= '0;
            state <= brms_pkg::S_ROOT;
          end else begin
            rem  <= alu_ge ? alu_diff[brms_pkg::ALU_W-1:0] : alu_a;
            step <= step + 1'b1;
          end
        end
        brms_pkg::S_ROOT: begin
          rem  <= alu_ge ? alu_diff[brms_pkg::ALU_W-1:0] : alu_a;
          root <= {root[brms_pkg::ROOT_W-2:0], alu_ge};
          work <= {work[brms_pkg::WORK_W-3:0], 2'b00};
          step <= step + 1'b1;
          if (step == brms_pkg::STEP_W'(brms_pkg::ROOT_W - 1)) begin
            state <= brms_pkg::S_OUT;
          end
        end
        brms_pkg::S_OUT: begin
          if (out_free) begin
            dout.valid        <= 1'b1;
            dout.rms_value    <= rms_sat;
            dout.samples_used <= brms_pkg::USED_W'(count);
            count             <= '0;
            state             <= brms_pkg::S_IDLE;
          end
        end
        default: begin
          state <= brms_pkg::S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= brms_pkg::CNT_W'(brms_pkg::MAX_SAMPLES))
    else $error("sample count passed the block limit");

  a_accept_to_acc: assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready) |=> (state == brms_pkg::S_ACC))
    else $error("accepted item did not move to accumulation");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(dout.valid) |-> $past(state == brms_pkg::S_OUT))
    else $error("result appeared outside the output state");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    $rose(dout.valid) |-> (dout.samples_used != '0))
    else $error("result reported an empty block");

  a_div_steps: assert property (@(posedge clk) disable iff (rst)
    (state == brms_pkg::S_DIV) |-> (step < brms_pkg::STEP_W'(brms_pkg::WORK_W)))
    else $error("divide ran past its step count");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Block RMS meter core testbench
// Sends blocks of PCM samples through the valid/ready input channel and checks
// every reported RMS value and sample count against a predictor running
// alongside the stimulus. A short directed table comes first, then random
// blocks under changing idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import brms_pkg::*;

  localparam int ITEM_TARGET  = 1600;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int N_DIR        = 11;

  typedef struct packed {
    logic [RMS_W-1:0]  rms;
    logic [USED_W-1:0] used;
  } meter_res_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [7:0]             reps;
    logic                   last;
    logic                   typed;
    logic [RMS_W-1:0]       rms;
    logic [USED_W-1:0]      used;
  } stim_row_t;

  logic clk;
  logic rst;

  brms_in_if  in_ch ();
  brms_out_if out_ch ();

  block_rms_meter_core dut (
    .clk  (clk),
    .rst  (rst),
    .din  (in_ch),
    .dout (out_ch)
  );

  // Each row is a run of identical samples; the block ends on the final item of
  // the run only when the row's last flag is set.
  stim_row_t dir_rows [N_DIR] = '{
    '{16'h0000, 8'd1,  1'b1, 1'b1, 16'd0,     6'd1},
    '{16'h8000, 8'd1,  1'b1, 1'b1, 16'd32768, 6'd1},
    '{16'h7FFF, 8'd1,  1'b1, 1'b1, 16'd32767, 6'd1},
    '{16'h8001, 8'd1,  1'b1, 1'b1, 16'd32767, 6'd1},
    '{16'h0001, 8'd1,  1'b1, 1'b1, 16'd1,     6'd1},
    '{16'hFFFF, 8'd1,  1'b1, 1'b1, 16'd1,     6'd1},
    '{16'h5555, 8'd1,  1'b0, 1'b0, 16'd0,     6'd0},
    '{16'hAAAA, 8'd1,  1'b1, 1'b0, 16'd0,     6'd0},
    '{16'h0003, 8'd1,  1'b0, 1'b0, 16'd0,     6'd0},
    '{16'h0004, 8'd1,  1'b1, 1'b0, 16'd0,     6'd0},
    '{16'h8000, 8'd33, 1'b1, 1'b1, 16'd32768, 6'd32}
  };

  logic [SUM_W-1:0] sq_sum;
  logic [CNT_W-1:0] blk_count;
  meter_res_t       pending_rms [$];

  int          samples_sent;
  int          mismatches;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_req;
  logic        hold_done;
  int          hold_left;
  int          quiet_cycles;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [ROOT_W-1:0] floor_root(input logic [SUM_W-1:0] v);
    logic [ROOT_W-1:0] r;
    logic [ROOT_W-1:0] t;
    logic [WORK_W-1:0] trial_sq;
    r = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      t = r | (ROOT_W'(1) << b);
      trial_sq = WORK_W'(t);
      trial_sq = trial_sq * trial_sq;
      if (trial_sq <= WORK_W'(v)) r = t;
    end
    return r;
  endfunction

  // Accumulates one sample into the running block and, on the final sample,
  // produces the block's RMS and count and clears the block.
  task automatic meter_accumulate(input logic [SAMPLE_BITS-1:0] s, input logic last,
                                  output logic has_res, output meter_res_t res);
    logic [SAMPLE_BITS:0] mag;
    logic [SUM_W-1:0]     sq;
    logic [SUM_W-1:0]     mean;
    logic [ROOT_W-1:0]    root;
    mag = s[SAMPLE_BITS-1] ? -{1'b1, s} : {1'b0, s};
    if (blk_count < CNT_W'(MAX_SAMPLES)) begin
      sq = SUM_W'(mag);
      sq = sq * sq;
      sq_sum = sq_sum + sq;
      blk_count = blk_count + 1'b1;
    end
    has_res = last;
    res = '0;
    if (last) begin
      mean = sq_sum / SUM_W'(blk_count);
      root = floor_root(mean);
      res.rms = (root > ROOT_W'({RMS_W{1'b1}})) ? {RMS_W{1'b1}} : RMS_W'(root);
      res.used = USED_W'(blk_count);
      sq_sum = '0;
      blk_count = '0;
    end
  endtask

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Offers one item, waits for it to be taken and queues what it should cause.
  // A typed result replaces the predicted one for rows whose answer is known.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic last,
                             input logic typed, input meter_res_t typed_res);
    logic       has_res;
    meter_res_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.sample        <= s;
    in_ch.last_in_block <= last;
    do @(posedge clk); while (!in_ch.ready);
    samples_sent++;
    meter_accumulate(s, last, has_res, res);
    if (has_res) pending_rms.push_back(typed ? typed_res : res);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    logic [SAMPLE_BITS-1:0] s;
    case ($urandom_range(9))
      0: s = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      1: s = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      2: begin
        s = SAMPLE_BITS'($urandom_range(15));
        if ($urandom_range(1) == 1) s = -s;
      end
      default: s = SAMPLE_BITS'($urandom);
    endcase
    return s;
  endfunction

  // Result side: random back-pressure, plus one long hold while the input
  // keeps offering, so the core fills up and stops taking samples.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    meter_res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_rms.size() == 0) begin
        report($sformatf("result with none expected: rms_value %0d samples_used %0d",
                         out_ch.rms_value, out_ch.samples_used));
      end else begin
        want = pending_rms.pop_front();
        if (out_ch.rms_value !== want.rms)
          report($sformatf("rms_value expected %0d got %0d", want.rms, out_ch.rms_value));
        if (out_ch.samples_used !== want.used)
          report($sformatf("samples_used expected %0d got %0d", want.used,
                           out_ch.samples_used));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int blk_len;
    meter_res_t typed_res;
    rst                 = 1'b1;
    in_ch.valid         = 1'b0;
    in_ch.sample        = '0;
    in_ch.last_in_block = 1'b0;
    hold_req            = 1'b0;
    send_idle_pct       = 15;
    recv_idle_pct       = 75;
    sq_sum              = '0;
    blk_count           = '0;
    samples_sent        = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      typed_res.rms  = dir_rows[i].rms;
      typed_res.used = dir_rows[i].used;
      for (int k = 0; k < int'(dir_rows[i].reps); k++) begin
        send_sample(dir_rows[i].sample, dir_rows[i].last && (k == dir_rows[i].reps - 1),
                    dir_rows[i].typed, typed_res);
      end
    end

    while (samples_sent < ITEM_TARGET) begin
      if (samples_sent < ITEM_TARGET / 3) begin
        send_idle_pct <= 15;
        recv_idle_pct <= 75;
      end else if (samples_sent < 2 * ITEM_TARGET / 3) begin
        send_idle_pct <= 75;
        recv_idle_pct <= 15;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        hold_req      <= 1'b1;
      end
      // Mostly short blocks so results are frequent; some straddle the clamp.
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: blk_len = $urandom_range(1, 6);
        6, 7:             blk_len = $urandom_range(7, 20);
        default:          blk_len = $urandom_range(29, 40);
      endcase
      for (int k = 0; k < blk_len; k++)
        send_sample(pick_sample(), k == blk_len - 1, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (pending_rms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_rms.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- block_rms_meter_core.f -----
rtl/brms_pkg.sv
rtl/brms_if.sv
rtl/block_rms_meter_core.sv
tb/tb_top.sv
